// File: hw/rtl/tksq_pkg.sv
// Shared types and constants for the two-key sorted priority queue.
package tksq_pkg;

    localparam int CAPACITY     = 16;
    localparam int ID_BITS      = 16;
    localparam int KEY_BITS     = 8;
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int S_FIELD_BITS = ID_BITS + 2 * KEY_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * ID_BITS + CNT_BITS + 3;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Result field offsets in m_tdata
    localparam int M_FRONT_LSB   = 0;
    localparam int M_EMPTY_BIT   = ID_BITS;
    localparam int M_COUNT_LSB   = ID_BITS + 1;
    localparam int M_REMOVED_LSB = ID_BITS + 1 + CNT_BITS;
    localparam int M_RVALID_BIT  = 2 * ID_BITS + 1 + CNT_BITS;
    localparam int M_DROP_BIT    = 2 * ID_BITS + 2 + CNT_BITS;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] major;
        logic [KEY_BITS-1:0] minor;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

// File: hw/rtl/tksq_cell.sv
// One slot of the sorted chain: holds an entry and shifts or inserts on command.
module tksq_cell (
    input  logic                aclk,
    input  tksq_pkg::cell_ctl_t ctl,
    input  tksq_pkg::entry_t    new_entry,
    input  tksq_pkg::entry_t    left_entry,
    input  tksq_pkg::entry_t    right_entry,
    input  logic                left_keep,
    input  logic                occupied,
    output tksq_pkg::entry_t    entry,
    output tksq_pkg::entry_t    entry_next,
    output logic                keep
);

    tksq_pkg::entry_t entry_reg;

    assign entry = entry_reg;

    always_comb begin
        keep = occupied &&
               ({entry_reg.major, entry_reg.minor} >= {new_entry.major, new_entry.minor});
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.push) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (ctl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: hw/rtl/two_key_sorted_priority_queue.sv
// Top level: two-key sorted priority queue built as a shifting chain of cells.
// The result of an item is registered and presented in the cycle after its input transfer.
// Throughput: one push or pop per cycle while s_tready is high; every cell compares and shifts in parallel.
// A result waiting on m_tready blocks input only when it is not taken that cycle.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// Slot contents are not cleared; the entry count alone marks which slots hold data.
module two_key_sorted_priority_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // lsb up: item_id, major_urgency, minor_urgency
    input  logic [tksq_pkg::S_DATA_BITS-1:0] s_tdata,
    // cmd
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // lsb up: front_id, is_empty, entry_count, removed_id, removed_valid, push_dropped
    output logic [tksq_pkg::M_DATA_BITS-1:0] m_tdata
);

    localparam int CAP = tksq_pkg::CAPACITY;
    localparam int IDB = tksq_pkg::ID_BITS;
    localparam int KB  = tksq_pkg::KEY_BITS;
    localparam int CB  = tksq_pkg::CNT_BITS;

    logic [CB-1:0]                    count_reg, count_next;
    logic                             m_valid_reg, m_valid_next;
    logic [tksq_pkg::M_DATA_BITS-1:0] m_data_reg, m_data_next;

    tksq_pkg::entry_t    new_entry;
    tksq_pkg::entry_t    cell_q [CAP];
    tksq_pkg::entry_t    cell_nx [CAP];
    logic [CAP-1:0]      keep;
    tksq_pkg::cell_ctl_t ctl;
    tksq_pkg::cmd_t      cmd;
    logic                accept, full, empty_now;
    logic [IDB-1:0]      front_id, removed_id;
    logic                removed_valid, push_dropped, is_empty;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = tksq_pkg::cmd_t'(s_tuser[0]);
    assign full     = (count_reg == CB'(CAP));
    assign empty_now = (count_reg == '0);

    always_comb begin
        new_entry.id    = s_tdata[IDB-1:0];
        new_entry.major = s_tdata[IDB +: KB];
        new_entry.minor = s_tdata[IDB+KB +: KB];
    end

    always_comb begin
        ctl.push = accept && (cmd == tksq_pkg::CMD_PUSH) && !full;
        ctl.pop  = accept && (cmd == tksq_pkg::CMD_POP) && !empty_now;
    end

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        localparam logic [CB-1:0] IDX = CB'(i);
        tksq_pkg::entry_t left_e, right_e;
        logic             left_k;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end else begin : g_mid
            assign left_e = cell_q[i-1];
            assign left_k = keep[i-1];
        end

        if (i == CAP - 1) begin : g_tail
            assign right_e = new_entry;
        end else begin : g_body
            assign right_e = cell_q[i+1];
        end

        tksq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_keep   (left_k),
            .occupied    (IDX < count_reg),
            .entry       (cell_q[i]),
            .entry_next  (cell_nx[i]),
            .keep        (keep[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.push) begin
            count_next = count_reg + CB'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CB'(1);
        end
    end

    always_comb begin
        is_empty      = (count_next == '0);
        front_id      = is_empty ? '0 : cell_nx[0].id;
        removed_valid = ctl.pop;
        removed_id    = ctl.pop ? cell_q[0].id : '0;
        push_dropped  = accept && (cmd == tksq_pkg::CMD_PUSH) && full;
        m_data_next   = tksq_pkg::M_DATA_BITS'({push_dropped, removed_valid, removed_id,
                                                count_next, is_empty, front_id});
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/tksq_checker.sv
// Port-level checks for the two-key sorted priority queue, bound to the top level.
module tksq_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tksq_pkg::M_DATA_BITS-1:0] m_tdata
);

    localparam int IDB = tksq_pkg::ID_BITS;
    localparam int CB  = tksq_pkg::CNT_BITS;

    logic [CB-1:0]  cnt;
    logic [IDB-1:0] front, rid;
    logic           emp, rv, pd, in_xfer;

    assign cnt     = m_tdata[tksq_pkg::M_COUNT_LSB +: CB];
    assign front   = m_tdata[tksq_pkg::M_FRONT_LSB +: IDB];
    assign rid     = m_tdata[tksq_pkg::M_REMOVED_LSB +: IDB];
    assign emp     = m_tdata[tksq_pkg::M_EMPTY_BIT];
    assign rv      = m_tdata[tksq_pkg::M_RVALID_BIT];
    assign pd      = m_tdata[tksq_pkg::M_DROP_BIT];
    assign in_xfer = s_tvalid && s_tready;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt <= CB'(tksq_pkg::CAPACITY)))
        else $error("entry count above capacity");

    a_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((emp == (cnt == '0)) && (!emp || front == '0)))
        else $error("empty flag disagrees with count or front id");

    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!(rv && pd) && (rv || rid == '0)))
        else $error("inconsistent removal and drop flags");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !in_xfer) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind two_key_sorted_priority_queue tksq_checker u_tksq_checker (.*);
